>>> rtl/rpg_pkg.sv
// Package of the rhythm pattern generator: constants, payload and control types.
package rpg_pkg;

  localparam int MaxSteps    = 64;
  localparam int BinMaxSteps = 32;
  localparam int IdxW        = $clog2(MaxSteps);

  localparam logic OpPolygon = 1'b0;
  localparam logic OpBinary  = 1'b1;

  localparam logic [63:0] ResetPattern = 64'd73;
  localparam logic [6:0]  ResetLength  = 7'd8;
  localparam logic [6:0]  ResetOnsets  = 7'd3;

  typedef struct packed {
    logic              op;
    logic [6:0]        vertices;
    logic [6:0]        steps;
    logic signed [7:0] offset;
    logic [31:0]       binary_value;
  } rpg_in_t;

  typedef struct packed {
    logic        accepted;
    logic [63:0] pattern;
    logic [6:0]  step_count;
    logic [6:0]  onset_count;
  } rpg_out_t;

  typedef struct packed {
    logic load_req;
    logic clear_work;
    logic start_div_sv;
    logic start_div_off;
    logic latch_sv;
    logic init_poly;
    logic poly_step;
    logic bin_step;
    logic finish;
  } rpg_cmd_t;

  typedef struct packed {
    logic req_ok;
    logic req_bin;
    logic div_done;
    logic last_vertex;
    logic last_step;
  } rpg_sts_t;

endpackage

>>> rtl/rpg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module rpg_div (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [6:0] divisor_i,
  output logic       done_o,
  output logic [7:0] quot_o,
  output logic [6:0] rem_o
);

  logic [7:0] dvd_q, dvd_d;
  logic [6:0] dvs_q, dvs_d;
  logic [6:0] rem_q, rem_d;
  logic [7:0] quo_q, quo_d;
  logic [2:0] cnt_q, cnt_d;
  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [7:0] trial;
  logic       ge;

  assign trial = {rem_q, dvd_q[7]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[6:0], 1'b0};
      rem_d = ge ? 7'(trial - {1'b0, dvs_q}) : trial[6:0];
      quo_d = {quo_q[6:0], ge};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/rpg_datapath.sv
// Datapath: request register, polygon stepping, binary mapping, held pattern and output register.
module rpg_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rpg_pkg::rpg_in_t  in_data_i,
  input  rpg_pkg::rpg_cmd_t cmd_i,
  output rpg_pkg::rpg_sts_t sts_o,
  output rpg_pkg::rpg_out_t out_data_o
);
  import rpg_pkg::*;

  rpg_in_t           req_q;
  logic [6:0]        a_q;
  logic [7:0]        b_q;
  logic signed [16:0] num_q;
  logic [IdxW-1:0]   p_q;
  logic [7:0]        r_q;
  logic [6:0]        cnt_q;
  logic [63:0]       work_q;
  logic [6:0]        won_q;
  logic [63:0]       held_pat_q;
  logic [6:0]        held_len_q;
  logic [6:0]        held_on_q;
  rpg_out_t          out_q;

  logic              req_ok;
  logic              div_start;
  logic [7:0]        div_dvd;
  logic [6:0]        div_dvs;
  logic              div_done;
  logic [7:0]        div_quot;
  logic [6:0]        div_rem;
  logic [7:0]        abs_off;
  logic [IdxW-1:0]   p_init;
  logic signed [15:0] prod;
  logic              corr;
  logic [IdxW-1:0]   pidx;
  logic [8:0]        rsum;
  logic [8:0]        two_v;
  logic              carry;
  logic [7:0]        r_next;
  logic [7:0]        psum;
  logic [IdxW-1:0]   p_next;
  logic [IdxW-1:0]   bidx_step;
  logic [4:0]        bidx_val;
  logic              bbit;

  // Request check: both modes need a non-zero length within range.
  always_comb begin
    req_ok = (req_q.steps != 7'd0) && (req_q.steps <= 7'(MaxSteps));
    if (req_q.op == OpBinary) begin
      req_ok = req_ok && (req_q.steps <= 7'(BinMaxSteps));
    end else begin
      req_ok = req_ok && (req_q.vertices != 7'd0);
    end
  end

  assign abs_off   = req_q.offset[7] ? 8'(~req_q.offset + 8'sd1) : req_q.offset;
  assign div_start = cmd_i.start_div_sv | cmd_i.start_div_off;
  assign div_dvd   = cmd_i.start_div_sv ? {1'b0, req_q.steps} : abs_off;
  assign div_dvs   = cmd_i.start_div_sv ? req_q.vertices : req_q.steps;

  rpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // True modulo of the offset from the remainder of its magnitude.
  assign p_init = (req_q.offset[7] && (div_rem != 7'd0)) ?
                  IdxW'(req_q.steps - div_rem) : IdxW'(div_rem);
  assign prod   = req_q.offset * $signed({1'b0, req_q.vertices});

  // A negative numerator that divides exactly into a half rounds one step lower.
  assign corr = num_q[16] && (r_q == 8'd0);
  assign pidx = !corr ? p_q :
                (p_q == '0) ? IdxW'(req_q.steps - 7'd1) : p_q - IdxW'(1);

  assign two_v  = {1'b0, req_q.vertices, 1'b0};
  assign rsum   = {1'b0, r_q} + {1'b0, b_q};
  assign carry  = rsum >= two_v;
  assign r_next = carry ? 8'(rsum - two_v) : rsum[7:0];
  assign psum   = {{(8 - IdxW){1'b0}}, p_q} + {1'b0, a_q} + {7'd0, carry};
  assign p_next = (psum >= {1'b0, req_q.steps}) ?
                  IdxW'(psum - {1'b0, req_q.steps}) : IdxW'(psum);

  assign bidx_step = IdxW'(cnt_q);
  assign bidx_val  = 5'(req_q.steps - 7'd1 - cnt_q);
  assign bbit      = req_q.binary_value[bidx_val];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.clear_work) begin
      work_q <= '0;
      won_q  <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.latch_sv) begin
      a_q <= div_quot[6:0];
      b_q <= {div_rem, 1'b0};
    end
    if (cmd_i.init_poly) begin
      num_q <= 17'(prod);
      p_q   <= p_init;
      r_q   <= {1'b0, req_q.vertices};
      cnt_q <= '0;
    end
    if (cmd_i.poly_step) begin
      work_q[pidx] <= 1'b1;
      if (!work_q[pidx]) begin
        won_q <= won_q + 7'd1;
      end
      r_q   <= r_next;
      p_q   <= p_next;
      num_q <= num_q + $signed({10'd0, req_q.steps});
      cnt_q <= cnt_q + 7'd1;
    end
    if (cmd_i.bin_step) begin
      work_q[bidx_step] <= bbit;
      won_q <= won_q + {6'd0, bbit};
      cnt_q <= cnt_q + 7'd1;
    end
    if (cmd_i.finish) begin
      out_q.accepted    <= req_ok;
      out_q.pattern     <= req_ok ? work_q : held_pat_q;
      out_q.step_count  <= req_ok ? req_q.steps : held_len_q;
      out_q.onset_count <= req_ok ? won_q : held_on_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_pat_q <= ResetPattern;
      held_len_q <= ResetLength;
      held_on_q  <= ResetOnsets;
    end else if (cmd_i.finish && req_ok) begin
      held_pat_q <= work_q;
      held_len_q <= req_q.steps;
      held_on_q  <= won_q;
    end
  end

  assign sts_o.req_ok      = req_ok;
  assign sts_o.req_bin     = (req_q.op == OpBinary);
  assign sts_o.div_done    = div_done;
  assign sts_o.last_vertex = (cnt_q == 7'(req_q.vertices - 7'd1));
  assign sts_o.last_step   = (cnt_q == 7'(req_q.steps - 7'd1));
  assign out_data_o        = out_q;

endmodule

>>> rtl/rpg_ctrl.sv
// Controller state machine: sequences the check, divisions, stepping and result hand-off.
module rpg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  input  rpg_pkg::rpg_sts_t sts_i,
  output rpg_pkg::rpg_cmd_t cmd_o
);
  import rpg_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StDivSv,
    StDivOff,
    StPoly,
    StBin,
    StFinish
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = StCheck;
        end
      end
      StCheck: begin
        cmd_o.clear_work = 1'b1;
        if (!sts_i.req_ok) begin
          state_d = StFinish;
        end else if (sts_i.req_bin) begin
          state_d = StBin;
        end else begin
          cmd_o.start_div_sv = 1'b1;
          state_d            = StDivSv;
        end
      end
      StDivSv: begin
        if (sts_i.div_done) begin
          cmd_o.latch_sv      = 1'b1;
          cmd_o.start_div_off = 1'b1;
          state_d             = StDivOff;
        end
      end
      StDivOff: begin
        if (sts_i.div_done) begin
          cmd_o.init_poly = 1'b1;
          state_d         = StPoly;
        end
      end
      StPoly: begin
        cmd_o.poly_step = 1'b1;
        if (sts_i.last_vertex) begin
          state_d = StFinish;
        end
      end
      StBin: begin
        cmd_o.bin_step = 1'b1;
        if (sts_i.last_step) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/rhythm_pattern_generator.sv
// Top level of the rhythm pattern generator: controller, datapath and checks.
//
// Usage. A request item arrives on the in channel (in_valid_i, in_ready_o,
// in_data_i) and exactly one result item leaves on the out channel
// (out_valid_o, out_ready_i, out_data_o), in request order. An item moves
// when valid and ready are both high at a rising edge of clk_i.
// Timing. A request first passes the check state. A rejected request then
// goes straight to the finish state. A binary request walks one step per
// cycle. A polygon request runs two 8-step divisions in the shared
// iterative divider (steps by vertices, then the offset magnitude by steps)
// and places one vertex per cycle. One request is in work at a time;
// in_ready_o rises together with the registered result.
// Stalls. If the receiver holds out_ready_i low, the finished result stays
// in the output register; a following request is taken and worked on, and
// waits in its final state until that register has been emptied.
// Reset. rst_ni is asynchronous and active low; it empties the output
// register and loads the held pattern with steps 0, 3 and 6 of 8 set.
module rhythm_pattern_generator (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rpg_pkg::rpg_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rpg_pkg::rpg_out_t out_data_o
);
  import rpg_pkg::*;

  rpg_cmd_t cmd;
  rpg_sts_t sts;

  // The controller only issues commands and watches status; all payload
  // lives in the datapath.
  rpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rpg_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // Once a request is taken the block is busy in its check state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while the previous one was still in work");

  // A reported pattern is never longer than the supported maximum nor empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.step_count != 7'd0 &&
                     out_data_o.step_count <= 7'(MaxSteps)))
    else $error("result length out of range");

  // The onset count cannot exceed the length of the pattern.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.onset_count <= out_data_o.step_count))
    else $error("onset count exceeds pattern length");

  // No onset may lie at or beyond the pattern length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.pattern >> out_data_o.step_count) == 64'd0))
    else $error("onset beyond pattern length");

endmodule

>>> tb/testbench.sv
// Self-checking testbench of the rhythm pattern generator with its pattern scoreboard.
`timescale 1ns / 1ps

module testbench;
  import rpg_pkg::*;

  // The scoreboard keeps its own copy of the held pattern and held length.
  // For every accepted request it works out the answer that the block owes.
  // It then compares each answer that leaves the block, field by field, with
  // the oldest answer still owed.
  class pattern_scoreboard;
    logic [63:0] held_bits;
    logic [6:0]  held_steps;
    rpg_out_t    due_answers[$];
    int          mismatches;
    int          polygons_built;
    int          binaries_built;
    int          requests_refused;

    function new();
      held_bits        = ResetPattern;
      held_steps       = ResetLength;
      mismatches       = 0;
      polygons_built   = 0;
      binaries_built   = 0;
      requests_refused = 0;
    endfunction

    // Places every corner of the polygon. The division is rounded half away
    // from zero, and the modulo always lands in 0..steps-1.
    function automatic logic [63:0] polygon_bits(rpg_in_t req);
      logic [63:0] bits;
      longint      corners;
      longint      len;
      longint      num;
      longint      quot;
      longint      pos;
      bits    = '0;
      corners = longint'(req.vertices);
      len     = longint'(req.steps);
      for (longint k = 0; k < corners; k++) begin
        num = k * len + longint'($signed(req.offset)) * corners;
        if (num >= 0) begin
          quot = (2 * num + corners) / (2 * corners);
        end else begin
          quot = -((-2 * num + corners) / (2 * corners));
        end
        pos = quot % len;
        if (pos < 0) begin
          pos += len;
        end
        bits[pos[5:0]] = 1'b1;
      end
      return bits;
    endfunction

    // The low steps bits of the value go onto the pattern, most significant first.
    function automatic logic [63:0] binary_bits(rpg_in_t req);
      logic [63:0] bits;
      bits = '0;
      for (int i = 0; i < int'(req.steps); i++) begin
        bits[i] = req.binary_value[int'(req.steps) - 1 - i];
      end
      return bits;
    endfunction

    function automatic void note_request(rpg_in_t req);
      rpg_out_t answer;
      logic     valid_req;
      if (req.op == OpPolygon) begin
        valid_req = (req.vertices != 0) && (req.steps != 0) && (req.steps <= MaxSteps);
      end else begin
        valid_req = (req.steps != 0) && (req.steps <= BinMaxSteps);
      end
      if (valid_req) begin
        held_bits  = (req.op == OpPolygon) ? polygon_bits(req) : binary_bits(req);
        held_steps = req.steps;
        if (req.op == OpPolygon) begin
          polygons_built++;
        end else begin
          binaries_built++;
        end
      end else begin
        requests_refused++;
      end
      answer.accepted    = valid_req;
      answer.pattern     = held_bits;
      answer.step_count  = held_steps;
      answer.onset_count = 7'($countones(held_bits));
      due_answers = {due_answers, answer};
    endfunction

    function automatic void check_answer(rpg_out_t got);
      rpg_out_t want;
      if (due_answers.size() == 0) begin
        $error("answer with no request waiting: pattern %h", got.pattern);
        mismatches++;
        return;
      end
      want = due_answers.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        mismatches++;
      end
      if (got.pattern !== want.pattern) begin
        $error("pattern: expected %h, got %h", want.pattern, got.pattern);
        mismatches++;
      end
      if (got.step_count !== want.step_count) begin
        $error("step_count: expected %0d, got %0d", want.step_count, got.step_count);
        mismatches++;
      end
      if (got.onset_count !== want.onset_count) begin
        $error("onset_count: expected %0d, got %0d", want.onset_count, got.onset_count);
        mismatches++;
      end
    endfunction
  endclass

  localparam int QuietLimit  = 6000;
  localparam int RandomItems = 780;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  rpg_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  rpg_out_t out_data_o;

  // Idle rates in percent of cycles, changed between the phases of the run.
  int send_idle_pct = 23;
  int recv_idle_pct = 87;

  pattern_scoreboard board = new();

  rhythm_pattern_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The receiver draws its ready afresh at every falling edge, so that its
  // stalls land on every phase of the block's work.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result items are taken at the rising edge and handed to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_answer(out_data_o);
    end
  end

  // The watchdog ends the run if no item moves on either side for too long.
  // The limit lies far above the work of the slowest request, so it
  // leaves ample room for long stalls of the receiver.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench NOT OK");
    $finish;
  end

  // Presents one request item. Valid is only lowered during an idle gap, so
  // back-to-back items keep it high without a second assignment in a step.
  task automatic send_request(input rpg_in_t req);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    board.note_request(req);
  endtask

  task automatic send_fields(input logic op, input int corners, input int len,
                             input int rot, input logic [31:0] value);
    rpg_in_t req;
    req.op           = op;
    req.vertices     = 7'(corners);
    req.steps        = 7'(len);
    req.offset       = 8'(rot);
    req.binary_value = value;
    send_request(req);
  endtask

  // Holds the sender back until every owed answer has come out.
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.due_answers.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Most random items are well-formed requests; polygons mostly have small lengths,
  // a few use the largest lengths or more corners than steps. The rest is raw noise
  // over every bit of every field, which also yields the refused cases.
  function automatic rpg_in_t random_request();
    rpg_in_t req;
    req.binary_value = $urandom();
    req.offset       = 8'($urandom_range(255));
    req.op           = 1'($urandom_range(1));
    if ($urandom_range(99) < 15) begin
      req.vertices = 7'($urandom_range(127));
      req.steps    = 7'($urandom_range(127));
    end else if (req.op == OpBinary) begin
      req.vertices = 7'($urandom_range(127));
      req.steps    = 7'($urandom_range(BinMaxSteps, 1));
    end else begin
      req.steps    = ($urandom_range(99) < 85) ? 7'($urandom_range(16, 1))
                                               : 7'($urandom_range(MaxSteps, 1));
      req.vertices = ($urandom_range(99) < 80) ? 7'($urandom_range(req.steps, 1))
                                               : 7'($urandom_range(127, 1));
    end
    return req;
  endfunction

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: the plain cases, the extremes of every field, rounding
    // of exact halves on both sides of zero, and every kind of refusal.
    send_fields(OpPolygon, 3, 8, 0, 32'h0);
    send_fields(OpPolygon, 1, 1, 0, 32'h0);
    send_fields(OpPolygon, 64, 64, 127, 32'hFFFF_FFFF);
    send_fields(OpPolygon, 127, 64, -128, 32'h0);
    send_fields(OpPolygon, 2, 5, 1, 32'h0);
    send_fields(OpPolygon, 2, 5, -3, 32'h0);
    send_fields(OpPolygon, 5, 12, -1, 32'h0);
    send_fields(OpPolygon, 7, 64, -128, 32'h0);
    send_fields(OpPolygon, 9, 4, 5, 32'h0);
    send_fields(OpPolygon, 0, 8, 0, 32'h0);
    send_fields(OpPolygon, 3, 0, 0, 32'h0);
    send_fields(OpPolygon, 3, 65, 0, 32'h0);
    send_fields(OpPolygon, 127, 127, -1, 32'hFFFF_FFFF);
    send_fields(OpBinary, 0, 32, 0, 32'hFFFF_FFFF);
    send_fields(OpBinary, 127, 32, -128, 32'h8000_0001);
    send_fields(OpBinary, 0, 1, 0, 32'h0000_0001);
    send_fields(OpBinary, 0, 16, 0, 32'hA5A5_1234);
    send_fields(OpBinary, 0, 33, 0, 32'hFFFF_FFFF);
    send_fields(OpBinary, 0, 0, 0, 32'hFFFF_FFFF);
    send_fields(OpBinary, 0, 64, 0, 32'h1234_5678);
    send_fields(OpBinary, 0, 127, 127, 32'h0);
    send_fields(OpBinary, 5, 8, 0, 32'h0000_0000);

    // The sender rests here until the block has answered everything.
    wait_for_drain();

    // Random part in three phases: a slow receiver, then a slow sender,
    // then both sides at full rate.
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 3) begin
        send_idle_pct = 87;
        recv_idle_pct = 23;
      end else if (i == 2 * RandomItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_request(random_request());
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.due_answers.size() != 0) begin
      @(posedge clk_i);
    end
    // A stray extra answer would show up within these cycles.
    repeat (40) @(posedge clk_i);

    $display("Covered %0d polygon and %0d binary patterns built, %0d requests refused.",
             board.polygons_built, board.binaries_built, board.requests_refused);
    $display("Idle mixes: slow receiver, slow sender, then no idling on either side.");
    if (board.mismatches == 0 && board.due_answers.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rpg_pkg.sv
rtl/rpg_div.sv
rtl/rpg_datapath.sv
rtl/rpg_ctrl.sv
rtl/rhythm_pattern_generator.sv
tb/testbench.sv
